/* hw/rtl/quaternion_vector_rotate_assert.svh */
// Assertion macros shared by the checker of the quaternion vector rotator.
// Self-contained; the checker file includes it by name.
`ifndef QUATERNION_VECTOR_ROTATE_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define QVR_ASSERT_IMP(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define QVR_ASSERT_NXT(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/qvr_pkg.sv */
// Package of the quaternion vector rotator: formats, derived widths, types, codes.
// No dependencies; the interfaces, modules and checker of the RTL import it.
package qvr_pkg;

  localparam int VEC_WIDTH = 16;
  localparam int QUAT_FRAC = 14;
  localparam int QUAT_BITS = 16;
  localparam int NUM_LANES = 3;

  localparam int PROD_W    = 2 * QUAT_BITS;
  localparam int ENTRY_W   = PROD_W + 2;
  localparam int COEF_W    = ENTRY_W - QUAT_FRAC;
  localparam int MUL_W     = COEF_W + VEC_WIDTH;
  localparam int SUM_W     = MUL_W + 2;
  localparam int RND_RAW_W = SUM_W - QUAT_FRAC;
  localparam int RND_W     = (RND_RAW_W > VEC_WIDTH) ? RND_RAW_W : VEC_WIDTH + 1;

  localparam logic CMD_ROTATE  = 1'b0;
  localparam logic CMD_INVERSE = 1'b1;

  typedef logic signed [QUAT_BITS-1:0] quat_t;
  typedef logic signed [VEC_WIDTH-1:0] vec_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [COEF_W-1:0]    coef_t;

  typedef coef_t coef_row_t [NUM_LANES];
  typedef coef_t coef_mat_t [NUM_LANES][NUM_LANES];
  typedef vec_t  vec_arr_t  [NUM_LANES];

  localparam vec_t VEC_MAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
  localparam vec_t VEC_MIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } qvr_pipe_en_t;

endpackage

/* hw/rtl/qvr_if.sv */
// Stream interfaces of the quaternion vector rotator: input items and result items.
// Depends on qvr_pkg for the payload types.
interface qvr_in_if import qvr_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  command;
  quat_t quat_s;
  quat_t quat_i;
  quat_t quat_j;
  quat_t quat_k;
  vec_t  vec_x;
  vec_t  vec_y;
  vec_t  vec_z;

  modport source (output valid, command, quat_s, quat_i, quat_j, quat_k, vec_x, vec_y, vec_z,
                  input ready);
  modport sink   (input valid, command, quat_s, quat_i, quat_j, quat_k, vec_x, vec_y, vec_z,
                  output ready);
endinterface

interface qvr_out_if import qvr_pkg::*; ();
  logic valid;
  logic ready;
  vec_t rot_x;
  vec_t rot_y;
  vec_t rot_z;
  logic clipped;

  modport source (output valid, rot_x, rot_y, rot_z, clipped, input ready);
  modport sink   (input valid, rot_x, rot_y, rot_z, clipped, output ready);
endinterface

/* hw/rtl/qvr_matrix.sv */
// Rotation matrix builder: ten quaternion products, then rounded and optionally
// transposed matrix coefficients, two pipeline stages. Depends on qvr_pkg.
module qvr_matrix import qvr_pkg::*; (
  input  logic         clk,
  input  qvr_pipe_en_t pipe_en,
  input  logic         command,
  input  quat_t        quat_s,
  input  quat_t        quat_i,
  input  quat_t        quat_j,
  input  quat_t        quat_k,
  output coef_mat_t    coef
);

  typedef logic signed [ENTRY_W-1:0] entry_t;

  localparam entry_t COEF_HALF = entry_t'(1) <<< (QUAT_FRAC - 1);

  prod_t ss_r, aa_r, bb_r, cc_r, ab_r, ac_r, bc_r, sa_r, sb_r, sc_r;
  logic  cmd_r;
  entry_t    ent [NUM_LANES][NUM_LANES];
  coef_mat_t rnd;
  coef_mat_t coef_nxt;
  coef_mat_t coef_r;

  function automatic entry_t ext(input prod_t p);
    return entry_t'(p);
  endfunction

  function automatic coef_t round_coef(input entry_t e);
    entry_t biased;
    entry_t shifted;
    biased  = e + COEF_HALF;
    shifted = biased >>> QUAT_FRAC;
    return shifted[COEF_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (pipe_en.s1) begin
      ss_r  <= prod_t'(quat_s) * prod_t'(quat_s);
      aa_r  <= prod_t'(quat_i) * prod_t'(quat_i);
      bb_r  <= prod_t'(quat_j) * prod_t'(quat_j);
      cc_r  <= prod_t'(quat_k) * prod_t'(quat_k);
      ab_r  <= prod_t'(quat_i) * prod_t'(quat_j);
      ac_r  <= prod_t'(quat_i) * prod_t'(quat_k);
      bc_r  <= prod_t'(quat_j) * prod_t'(quat_k);
      sa_r  <= prod_t'(quat_s) * prod_t'(quat_i);
      sb_r  <= prod_t'(quat_s) * prod_t'(quat_j);
      sc_r  <= prod_t'(quat_s) * prod_t'(quat_k);
      cmd_r <= command;
    end
  end

  always_comb begin
    ent[0][0] = ext(ss_r) + ext(aa_r) - ext(bb_r) - ext(cc_r);
    ent[0][1] = (ext(ab_r) - ext(sc_r)) <<< 1;
    ent[0][2] = (ext(ac_r) + ext(sb_r)) <<< 1;
    ent[1][0] = (ext(ab_r) + ext(sc_r)) <<< 1;
    ent[1][1] = ext(ss_r) - ext(aa_r) + ext(bb_r) - ext(cc_r);
    ent[1][2] = (ext(bc_r) - ext(sa_r)) <<< 1;
    ent[2][0] = (ext(ac_r) - ext(sb_r)) <<< 1;
    ent[2][1] = (ext(bc_r) + ext(sa_r)) <<< 1;
    ent[2][2] = ext(ss_r) - ext(aa_r) - ext(bb_r) + ext(cc_r);
    for (int r = 0; r < NUM_LANES; r++) begin
      for (int j = 0; j < NUM_LANES; j++) begin
        rnd[r][j] = round_coef(ent[r][j]);
      end
    end
    for (int r = 0; r < NUM_LANES; r++) begin
      for (int j = 0; j < NUM_LANES; j++) begin
        coef_nxt[r][j] = (cmd_r == CMD_INVERSE) ? rnd[j][r] : rnd[r][j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en.s2) begin
      coef_r <= coef_nxt;
    end
  end

  assign coef = coef_r;

endmodule

/* hw/rtl/qvr_lane.sv */
// One output lane: dot product of a coefficient row with the vector, then rounding
// and saturation, two pipeline stages. Depends on qvr_pkg.
module qvr_lane import qvr_pkg::*; (
  input  logic         clk,
  input  qvr_pipe_en_t pipe_en,
  input  coef_row_t    coef_row,
  input  vec_arr_t     vec,
  output vec_t         res,
  output logic         hit
);

  typedef logic signed [MUL_W-1:0] mul_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [RND_W-1:0] rnd_t;

  localparam sum_t SUM_HALF = sum_t'(1) <<< (QUAT_FRAC - 1);

  mul_t mul_r [NUM_LANES];
  sum_t sum;
  sum_t shifted;
  rnd_t rnd;
  logic [RND_W-VEC_WIDTH:0] upper;
  logic over;
  vec_t res_nxt;
  vec_t res_r;
  logic hit_r;

  always_ff @(posedge clk) begin
    if (pipe_en.s3) begin
      for (int j = 0; j < NUM_LANES; j++) begin
        mul_r[j] <= mul_t'(coef_row[j]) * mul_t'(vec[j]);
      end
    end
  end

  always_comb begin
    sum = SUM_HALF;
    for (int j = 0; j < NUM_LANES; j++) begin
      sum = sum + sum_t'(mul_r[j]);
    end
    shifted = sum >>> QUAT_FRAC;
    rnd     = rnd_t'(shifted);
    upper   = rnd[RND_W-1:VEC_WIDTH-1];
    over    = !((&upper) || !(|upper));
    if (over) begin
      res_nxt = rnd[RND_W-1] ? VEC_MIN : VEC_MAX;
    end else begin
      res_nxt = rnd[VEC_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en.s4) begin
      res_r <= res_nxt;
      hit_r <= over;
    end
  end

  assign res = res_r;
  assign hit = hit_r;

endmodule

/* hw/rtl/quaternion_vector_rotate.sv */
// Top level of the quaternion vector rotator: valid tracking, stage enables, three
// row lanes and the merge register. Depends on qvr_pkg, qvr_if, qvr_matrix, qvr_lane.
// Each input transaction on in_chan carries a quaternion (quat_s scalar, quat_i, quat_j,
// quat_k vector parts, Q1.14) and a vector vec_x, vec_y, vec_z. command selects the
// forward rotation or the inverse one through the transposed matrix. One result
// transaction on out_chan carries rot_x, rot_y, rot_z, rounded and saturated, and
// clipped, set when any component saturated.
// Five register stages: products, matrix coefficients, lane multiplies, lane sums
// with rounding and saturation, and the output register that merges the lanes.
// Throughput is one transaction per cycle while out_chan is not stalled, set by the ten
// product multipliers and the three lanes of three multipliers, each used once per item.
// When out_chan.ready is low, each stage still fills if it is empty, so in_chan.ready
// stays high until all five stages hold an item; the held result does not change.
// A synchronous rst_n empties the pipeline; items in flight are lost, none is invented.
module quaternion_vector_rotate import qvr_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  qvr_in_if.sink          in_chan,
  qvr_out_if.source       out_chan
);

  qvr_pipe_en_t pipe_en;
  logic         out_en;
  logic [4:0]   vld_r;
  logic [4:0]   vld_nxt;
  vec_arr_t     vec_s1_r;
  vec_arr_t     vec_s2_r;
  coef_mat_t    coef;
  vec_arr_t     lane_res;
  logic [NUM_LANES-1:0] lane_hit;
  vec_arr_t     rot_r;
  logic         clipped_r;

  always_comb begin
    out_en     = !vld_r[4] || out_chan.ready;
    pipe_en.s4 = !vld_r[3] || out_en;
    pipe_en.s3 = !vld_r[2] || pipe_en.s4;
    pipe_en.s2 = !vld_r[1] || pipe_en.s3;
    pipe_en.s1 = !vld_r[0] || pipe_en.s2;
    vld_nxt[0] = pipe_en.s1 ? in_chan.valid : vld_r[0];
    vld_nxt[1] = pipe_en.s2 ? vld_r[0] : vld_r[1];
    vld_nxt[2] = pipe_en.s3 ? vld_r[1] : vld_r[2];
    vld_nxt[3] = pipe_en.s4 ? vld_r[2] : vld_r[3];
    vld_nxt[4] = out_en ? vld_r[3] : vld_r[4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en.s1) begin
      vec_s1_r[0] <= in_chan.vec_x;
      vec_s1_r[1] <= in_chan.vec_y;
      vec_s1_r[2] <= in_chan.vec_z;
    end
    if (pipe_en.s2) begin
      vec_s2_r <= vec_s1_r;
    end
  end

  qvr_matrix u_matrix (
    .clk     (clk),
    .pipe_en (pipe_en),
    .command (in_chan.command),
    .quat_s  (in_chan.quat_s),
    .quat_i  (in_chan.quat_i),
    .quat_j  (in_chan.quat_j),
    .quat_k  (in_chan.quat_k),
    .coef    (coef)
  );

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    qvr_lane u_lane (
      .clk      (clk),
      .pipe_en  (pipe_en),
      .coef_row (coef[g]),
      .vec      (vec_s2_r),
      .res      (lane_res[g]),
      .hit      (lane_hit[g])
    );
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      rot_r     <= lane_res;
      clipped_r <= |lane_hit;
    end
  end

  assign in_chan.ready    = pipe_en.s1;
  assign out_chan.valid   = vld_r[4];
  assign out_chan.rot_x   = rot_r[0];
  assign out_chan.rot_y   = rot_r[1];
  assign out_chan.rot_z   = rot_r[2];
  assign out_chan.clipped = clipped_r;

endmodule

/* hw/rtl/qvr_checker.sv */
// Port-level checker of the quaternion vector rotator and its bind to the top level.
// Depends on qvr_pkg and quaternion_vector_rotate_assert.svh.
`include "quaternion_vector_rotate_assert.svh"

module qvr_checker import qvr_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input vec_t rot_x,
  input vec_t rot_y,
  input vec_t rot_z,
  input logic clipped
);

  `QVR_ASSERT_NXT(a_out_hold, clk, !rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `QVR_ASSERT_NXT(a_out_stable, clk, !rst_n, out_valid && !out_ready, $stable(rot_x) && $stable(rot_y) && $stable(rot_z) && $stable(clipped), "result changed while stalled")
  `QVR_ASSERT_NXT(a_reset_flush, clk, 1'b0, !rst_n, !out_valid, "result valid after reset")
  `QVR_ASSERT_IMP(a_clip_extreme, clk, !rst_n, out_valid && clipped, (rot_x == VEC_MAX) || (rot_x == VEC_MIN) || (rot_y == VEC_MAX) || (rot_y == VEC_MIN) || (rot_z == VEC_MAX) || (rot_z == VEC_MIN), "clip flag without a saturated component")

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .rot_x     (out_chan.rot_x),
  .rot_y     (out_chan.rot_y),
  .rot_z     (out_chan.rot_z),
  .clipped   (out_chan.clipped)
);

/* tb/sv/rotation_checker.sv */
`timescale 1ns / 100ps
// Checker for the quaternion vector rotator: watches both stream interfaces, predicts
// each rotated vector and compares it with the block's result. Depends on qvr_pkg, qvr_if.
module rotation_checker import qvr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  qvr_in_if    in_mon,
  qvr_out_if   out_mon,
  output int   mismatch_count,
  output int   rotations_pending
);

  typedef struct packed {
    vec_t rot_x;
    vec_t rot_y;
    vec_t rot_z;
    logic clipped;
  } rotation_t;

  rotation_t expected_rotations[$];

  // Round half up by QUAT_FRAC bits; the arithmetic shift is a floor division.
  function automatic longint round_frac(longint x);
    return (x + (longint'(1) <<< (QUAT_FRAC - 1))) >>> QUAT_FRAC;
  endfunction

  function automatic rotation_t predict_rotation(logic command, quat_t qs, quat_t qi,
                                                 quat_t qj, quat_t qk, vec_t vx,
                                                 vec_t vy, vec_t vz);
    longint    s;
    longint    a;
    longint    b;
    longint    c;
    longint    m[3][3];
    longint    v[3];
    longint    acc;
    vec_t      lane[3];
    logic      clip;
    int        row;
    int        col;
    rotation_t r;
    s = longint'(qs);
    a = longint'(qi);
    b = longint'(qj);
    c = longint'(qk);
    v[0] = longint'(vx);
    v[1] = longint'(vy);
    v[2] = longint'(vz);
    m[0][0] = s*s + a*a - b*b - c*c;
    m[0][1] = 2 * (a*b - s*c);
    m[0][2] = 2 * (a*c + s*b);
    m[1][0] = 2 * (a*b + s*c);
    m[1][1] = s*s - a*a + b*b - c*c;
    m[1][2] = 2 * (b*c - s*a);
    m[2][0] = 2 * (a*c - s*b);
    m[2][1] = 2 * (b*c + s*a);
    m[2][2] = s*s - a*a - b*b + c*c;
    clip = 1'b0;
    for (row = 0; row < 3; row++) begin
      acc = 0;
      for (col = 0; col < 3; col++) begin
        acc += round_frac((command == CMD_INVERSE) ? m[col][row] : m[row][col]) * v[col];
      end
      acc = round_frac(acc);
      if (acc > longint'(VEC_MAX)) begin
        lane[row] = VEC_MAX;
        clip = 1'b1;
      end else if (acc < longint'(VEC_MIN)) begin
        lane[row] = VEC_MIN;
        clip = 1'b1;
      end else begin
        lane[row] = vec_t'(acc);
      end
    end
    r.rot_x = lane[0];
    r.rot_y = lane[1];
    r.rot_z = lane[2];
    r.clipped = clip;
    return r;
  endfunction

  task automatic check_field(string field, int expected, int actual);
    if (expected != actual) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, expected, actual);
      mismatch_count++;
    end
  endtask

  initial begin
    mismatch_count = 0;
    rotations_pending = 0;
  end

  always @(posedge clk) begin
    rotation_t got;
    rotation_t want;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        expected_rotations.push_back(predict_rotation(in_mon.command, in_mon.quat_s,
          in_mon.quat_i, in_mon.quat_j, in_mon.quat_k, in_mon.vec_x, in_mon.vec_y,
          in_mon.vec_z));
      end
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.rot_x, out_mon.rot_y, out_mon.rot_z, out_mon.clipped};
        if (expected_rotations.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0d %0d %0d clipped %0d",
                   $time, got.rot_x, got.rot_y, got.rot_z, got.clipped);
          mismatch_count++;
        end else begin
          want = expected_rotations.pop_front();
          check_field("rot_x", int'(want.rot_x), int'(got.rot_x));
          check_field("rot_y", int'(want.rot_y), int'(got.rot_y));
          check_field("rot_z", int'(want.rot_z), int'(got.rot_z));
          check_field("clipped", int'(want.clipped), int'(got.clipped));
        end
      end
      rotations_pending = expected_rotations.size();
    end
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// Top of the quaternion vector rotator testbench: clock, reset, directed and random
// stimulus with random stalls on both sides. Depends on qvr_pkg, qvr_if, rotation_checker.
module tb import qvr_pkg::*; ();

  typedef struct {
    logic  command;
    quat_t quat_s;
    quat_t quat_i;
    quat_t quat_j;
    quat_t quat_k;
    vec_t  vec_x;
    vec_t  vec_y;
    vec_t  vec_z;
  } rot_job_t;

  localparam int LONG_STALL = 60;
  localparam int RANDOM_JOBS = 500;
  localparam int HALF_TURN = 11585;

  logic clk;
  logic rst_n;
  int   mismatch_count;
  int   rotations_pending;
  bit   long_stall_req;

  qvr_in_if  in_chan ();
  qvr_out_if out_chan ();

  quaternion_vector_rotate dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  rotation_checker rot_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_mon            (in_chan),
    .out_mon           (out_chan),
    .mismatch_count    (mismatch_count),
    .rotations_pending (rotations_pending)
  );

  function automatic rot_job_t make_job(logic command, int s, int i, int j, int k,
                                        int x, int y, int z);
    rot_job_t job;
    job.command = command;
    job.quat_s = quat_t'(s);
    job.quat_i = quat_t'(i);
    job.quat_j = quat_t'(j);
    job.quat_k = quat_t'(k);
    job.vec_x = vec_t'(x);
    job.vec_y = vec_t'(y);
    job.vec_z = vec_t'(z);
    return job;
  endfunction

  function automatic int random_gap();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 12) return 0;
    if (pick < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic vec_t random_component();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return vec_t'($urandom);
    if (pick < 9) return vec_t'(int'($urandom_range(0, 200)) - 100);
    return $urandom_range(0, 1) ? VEC_MAX : VEC_MIN;
  endfunction

  // Most quaternions are unit length; the rest are raw in-range or arbitrary patterns.
  function automatic rot_job_t random_job();
    rot_job_t job;
    real      comp[4];
    real      norm;
    quat_t    q[4];
    int       kind;
    int       n;
    kind = $urandom_range(0, 19);
    norm = 0.0;
    for (n = 0; n < 4; n++) begin
      comp[n] = real'(int'($urandom_range(0, 32768)) - 16384);
      norm += comp[n] * comp[n];
    end
    norm = $sqrt(norm);
    if (norm < 1.0) begin
      comp[0] = 16384.0;
      norm = 16384.0;
    end
    for (n = 0; n < 4; n++) begin
      if (kind < 12) q[n] = quat_t'($rtoi(comp[n] * 16384.0 / norm));
      else if (kind < 16) q[n] = quat_t'($rtoi(comp[n]));
      else q[n] = quat_t'($urandom);
    end
    job.command = $urandom_range(0, 1) ? CMD_INVERSE : CMD_ROTATE;
    job.quat_s = q[0];
    job.quat_i = q[1];
    job.quat_j = q[2];
    job.quat_k = q[3];
    job.vec_x = random_component();
    job.vec_y = random_component();
    job.vec_z = random_component();
    return job;
  endfunction

  task automatic send_job(rot_job_t job, int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_chan.valid   <= 1'b1;
    in_chan.command <= job.command;
    in_chan.quat_s  <= job.quat_s;
    in_chan.quat_i  <= job.quat_i;
    in_chan.quat_j  <= job.quat_j;
    in_chan.quat_k  <= job.quat_k;
    in_chan.vec_x   <= job.vec_x;
    in_chan.vec_y   <= job.vec_y;
    in_chan.vec_z   <= job.vec_z;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (rotations_pending != 0) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int hold;
    int quiet;
    int pick;
    hold = 0;
    quiet = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_chan.ready <= 1'b0;
        hold--;
      end else if (long_stall_req) begin
        long_stall_req = 1'b0;
        hold = LONG_STALL - 1;
        out_chan.ready <= 1'b0;
      end else if (quiet > 0) begin
        out_chan.ready <= 1'b1;
        quiet--;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          hold = random_gap();
          out_chan.ready <= 1'b0;
        end else begin
          if (pick == 2) quiet = $urandom_range(20, 60);
          out_chan.ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    rot_job_t directed_jobs[$];
    int       burst;
    int       n;
    rst_n <= 1'b0;
    long_stall_req = 1'b0;
    in_chan.valid   <= 1'b0;
    in_chan.command <= CMD_ROTATE;
    in_chan.quat_s  <= '0;
    in_chan.quat_i  <= '0;
    in_chan.quat_j  <= '0;
    in_chan.quat_k  <= '0;
    in_chan.vec_x   <= '0;
    in_chan.vec_y   <= '0;
    in_chan.vec_z   <= '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed_jobs.push_back(make_job(CMD_ROTATE, 16384, 0, 0, 0, 1000, -2000, 3000));
    directed_jobs.push_back(make_job(CMD_INVERSE, 16384, 0, 0, 0, 1000, -2000, 3000));
    directed_jobs.push_back(make_job(CMD_ROTATE, 16384, 0, 0, 0, 32767, -32768, 32767));
    directed_jobs.push_back(make_job(CMD_ROTATE, 0, 0, 0, 0, 32767, 32767, 32767));
    directed_jobs.push_back(make_job(CMD_ROTATE, HALF_TURN, HALF_TURN, 0, 0, 12345, -321, 7));
    directed_jobs.push_back(make_job(CMD_INVERSE, HALF_TURN, HALF_TURN, 0, 0, 12345, -321, 7));
    directed_jobs.push_back(make_job(CMD_ROTATE, HALF_TURN, 0, HALF_TURN, 0, 100, 200, 300));
    directed_jobs.push_back(make_job(CMD_INVERSE, HALF_TURN, 0, HALF_TURN, 0, 100, 200, 300));
    directed_jobs.push_back(make_job(CMD_ROTATE, HALF_TURN, 0, 0, HALF_TURN, -5000, 25000, -1));
    directed_jobs.push_back(make_job(CMD_INVERSE, HALF_TURN, 0, 0, HALF_TURN, -5000, 25000, -1));
    directed_jobs.push_back(make_job(CMD_ROTATE, 8192, 8192, 8192, 8192, 1, -1, 1));
    directed_jobs.push_back(make_job(CMD_INVERSE, 8192, -8192, 8192, -8192, 32767, 0, -32768));
    directed_jobs.push_back(make_job(CMD_ROTATE, -32768, 0, 0, 0, 1, -1, 10000));
    directed_jobs.push_back(make_job(CMD_ROTATE, -32768, -32768, -32768, -32768,
                                     -32768, -32768, -32768));
    directed_jobs.push_back(make_job(CMD_INVERSE, 32767, 32767, 32767, 32767,
                                     32767, 32767, 32767));
    directed_jobs.push_back(make_job(CMD_ROTATE, 0, 16384, 0, 0, 30000, -30000, 1));
    directed_jobs.push_back(make_job(CMD_INVERSE, 16384, 16384, 16384, 16384, -32768, 32767, -1));
    directed_jobs.push_back(make_job(CMD_ROTATE, -16384, 0, 0, 0, -32768, -32768, -32768));
    directed_jobs.push_back(make_job(CMD_INVERSE, 1, -1, 1, -1, 32767, -32768, 32767));
    directed_jobs.push_back(make_job(CMD_ROTATE, 16384, 0, 0, 0, -1, 0, 1));
    foreach (directed_jobs[n]) send_job(directed_jobs[n], random_gap());
    wait_for_results();

    burst = 0;
    for (n = 0; n < RANDOM_JOBS; n++) begin
      // The receiver holds off for a long stretch while items keep coming back to back.
      if (n == 150) begin
        long_stall_req = 1'b1;
        burst = 30;
      end
      if (n == 330) wait_for_results();
      if (burst == 0 && $urandom_range(0, 19) == 0) burst = $urandom_range(15, 40);
      send_job(random_job(), (burst > 0) ? 0 : random_gap());
      if (burst > 0) burst--;
    end
    wait_for_results();
    repeat (10) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
